FILE: rtl/mccm_pkg.sv
package mccm_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int SPACING_RESET = 551;
    localparam logic [3:0] CC_STATUS_HI = 4'hB;
    localparam logic [7:0] NO_CHANGE = 8'hFF;

    localparam logic [2:0] REG_SMOOTH = 3'd0;
    localparam logic [2:0] REG_LEARN = 3'd1;
    localparam logic [2:0] REG_TRACKS = 3'd2;
    localparam logic [2:0] REG_STEPS = 3'd3;
    localparam logic [2:0] REG_SPACING = 3'd4;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_MIDI = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPD,
        ST_DIV,
        ST_RAMP,
        ST_OUT,
        ST_SCAN,
        ST_LEARN_OUT
    } state_t;

    // control change word: status byte for a 4-bit channel, then cc and value bytes
    function automatic logic [23:0] cc_word(input logic [3:0] ch, input logic [7:0] cc,
                                            input logic [7:0] val);
        cc_word = {val, cc, CC_STATUS_HI, ch};
    endfunction

endpackage

FILE: rtl/mccm_divider.sv
// Restoring divider: 24-bit magnitude over 7-bit divisor, one quotient bit per cycle
module mccm_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [23:0] dividend,
    input  logic [6:0]  divisor,
    output logic        busy,
    output logic [23:0] quotient
);
    logic [23:0] quo_reg, quo_next;
    logic [6:0]  rem_reg, rem_next;
    logic [6:0]  div_reg, div_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [7:0]  trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {rem_reg, quo_reg[23]};
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            div_next = divisor;
            cnt_next = 5'd24;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = 7'(trial - {1'b0, div_reg});
                quo_next = {quo_reg[22:0], 1'b1};
            end
            else
            begin
                rem_next = trial[6:0];
                quo_next = {quo_reg[22:0], 1'b0};
            end
            cnt_next = 5'(cnt_reg - 5'd1);
            if (cnt_reg == 5'd1)
                busy_next = 1'b0;
        end
    end

    assign busy = busy_reg;
    assign quotient = quo_reg;
endmodule

FILE: rtl/midi_cc_mapper_with_learn_top.sv
// Flow: a plain update passes ST_UPD and ST_OUT before its word is registered; a ramp
// starts the divider in ST_UPD and waits in ST_DIV (one quotient bit a cycle), then in ST_RAMP
// gives one word a cycle while the output is not stalled.
// Learn walks the slots one per cycle in ST_SCAN, then reports from ST_LEARN_OUT.
// Throughput: one item at a time; ready again once the last result is loaded for output.
// Reset: rst_n asynchronous, clears state and slot table, sets config defaults and stamp counter to one.
module midi_cc_mapper_with_learn_top #(
    parameter int SLOTS = mccm_pkg::SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [5:0]  slot,
    input  logic [7:0]  channel_in,
    input  logic [7:0]  cc_in,
    input  logic [7:0]  value_in,
    input  logic [7:0]  status,
    input  logic [7:0]  data1,
    input  logic [7:0]  data2,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [23:0] midi_word,
    output logic [21:0] time_offset,
    output logic [5:0]  learned_slot,
    output logic [4:0]  learned_channel,
    output logic [7:0]  learned_cc,
    output logic [7:0]  learned_value,
    output logic        last
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [6:0] SLOTS7 = 7'(SLOTS);

    mccm_pkg::state_t state_reg, state_next;

    logic        smooth_reg, learn_reg;
    logic [6:0]  tracks_reg, steps_reg;
    logic [15:0] spacing_reg;

    logic [3:0]  ch_tab [SLOTS];
    logic [7:0]  cc_tab [SLOTS];
    logic [7:0]  pv_tab [SLOTS];
    logic [31:0] st_tab [SLOTS];
    logic [31:0] stamp_reg;

    logic        cmd_reg;
    logic [5:0]  slot_reg;
    logic [7:0]  chi_reg, cci_reg, val_reg, sts_reg, d1_reg, d2_reg;

    logic [IW-1:0] idx_reg, pick_reg;
    logic [31:0] oldest_reg;
    logic        neg_reg;
    logic [24:0] step_reg;
    logic [24:0] acc_reg;
    logic [6:0]  n_reg, j_reg;
    logic [21:0] toff_reg;

    logic        ov_reg;
    logic        kind_reg, last_reg;
    logic [23:0] word_reg;
    logic [21:0] time_reg;
    logic [5:0]  ls_reg;
    logic [4:0]  lch_reg;
    logic [7:0]  lcc_reg, lval_reg;

    logic [6:0]  in_use;
    logic        accept;
    logic [IW-1:0] s_idx;
    logic        div_start, div_busy;
    logic [23:0] div_q, div_a;
    logic [8:0]  diff;
    logic [7:0]  diff_mag;

    assign in_use = (tracks_reg > SLOTS7) ? SLOTS7 : tracks_reg;
    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != mccm_pkg::ST_IDLE);
    assign s_idx = slot_reg[IW-1:0];
    assign diff = {1'b0, val_reg} - {1'b0, pv_tab[s_idx]};
    assign diff_mag = diff[8] ? 8'(-diff) : diff[7:0];
    // magnitude of the value change in Q8.16
    assign div_a = {diff_mag, 16'd0};

    mccm_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
        .divisor(n_reg), .busy(div_busy), .quotient(div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_reg <= 1'b0;
            learn_reg <= 1'b0;
            tracks_reg <= 7'd1;
            steps_reg <= 7'd1;
            spacing_reg <= 16'(mccm_pkg::SPACING_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mccm_pkg::REG_SMOOTH: smooth_reg <= cfg_data[0];
                mccm_pkg::REG_LEARN: learn_reg <= cfg_data[0];
                mccm_pkg::REG_TRACKS: tracks_reg <= cfg_data[6:0];
                mccm_pkg::REG_STEPS: steps_reg <= cfg_data[6:0];
                mccm_pkg::REG_SPACING: spacing_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
            slot_reg <= slot;
            chi_reg <= channel_in;
            cci_reg <= cc_in;
            val_reg <= value_in;
            sts_reg <= status;
            d1_reg <= data1;
            d2_reg <= data2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mccm_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        div_start = 1'b0;
        case (state_reg)
            mccm_pkg::ST_IDLE:
                if (accept)
                    state_next = (cmd == mccm_pkg::CMD_UPDATE) ? mccm_pkg::ST_UPD
                                                              : mccm_pkg::ST_SCAN;
            mccm_pkg::ST_UPD:
                if ({1'b0, slot_reg} >= in_use || val_reg == mccm_pkg::NO_CHANGE)
                    state_next = mccm_pkg::ST_IDLE;
                else if (!smooth_reg)
                    state_next = mccm_pkg::ST_OUT;
                else
                begin
                    div_start = 1'b1;
                    state_next = mccm_pkg::ST_DIV;
                end
            mccm_pkg::ST_DIV:
                if (!div_busy)
                    state_next = mccm_pkg::ST_RAMP;
            mccm_pkg::ST_RAMP:
                if (!ov_reg || !out_stall)
                    state_next = (j_reg == n_reg) ? mccm_pkg::ST_OUT : mccm_pkg::ST_RAMP;
            mccm_pkg::ST_OUT:
                if (!ov_reg || !out_stall)
                    state_next = mccm_pkg::ST_IDLE;
            mccm_pkg::ST_SCAN:
                if (sts_reg[7:4] != mccm_pkg::CC_STATUS_HI || !learn_reg)
                    state_next = mccm_pkg::ST_IDLE;
                else if ((ch_tab[idx_reg] == sts_reg[3:0] && cc_tab[idx_reg] == d1_reg)
                         || 7'(idx_reg) + 7'd1 >= in_use)
                    state_next = mccm_pkg::ST_LEARN_OUT;
            mccm_pkg::ST_LEARN_OUT:
                if (!ov_reg || !out_stall)
                    state_next = mccm_pkg::ST_IDLE;
            default: state_next = mccm_pkg::ST_IDLE;
        endcase
    end

    // datapath and table updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                ch_tab[i] <= '0;
                cc_tab[i] <= '0;
                pv_tab[i] <= '0;
                st_tab[i] <= '0;
            end
            stamp_reg <= 32'd1;
            ov_reg <= 1'b0;
            idx_reg <= '0;
            pick_reg <= '0;
            oldest_reg <= '0;
            neg_reg <= 1'b0;
            step_reg <= '0;
            acc_reg <= '0;
            n_reg <= 7'd1;
            j_reg <= '0;
            toff_reg <= '0;
        end
        else
        begin
            if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            case (state_reg)
                mccm_pkg::ST_IDLE:
                begin
                    idx_reg <= '0;
                    pick_reg <= '0;
                    oldest_reg <= st_tab[0];
                    n_reg <= (steps_reg == 7'd0) ? 7'd1 :
                             (steps_reg > 7'd64) ? 7'd64 : steps_reg;
                end
                mccm_pkg::ST_UPD:
                    if ({1'b0, slot_reg} < in_use)
                    begin
                        if (chi_reg != mccm_pkg::NO_CHANGE)
                            ch_tab[s_idx] <= 4'(chi_reg - 8'd1);
                        if (cci_reg != mccm_pkg::NO_CHANGE)
                            cc_tab[s_idx] <= cci_reg;
                        if (chi_reg != mccm_pkg::NO_CHANGE || cci_reg != mccm_pkg::NO_CHANGE
                            || val_reg != mccm_pkg::NO_CHANGE)
                            st_tab[s_idx] <= stamp_reg;
                        if (val_reg != mccm_pkg::NO_CHANGE)
                        begin
                            pv_tab[s_idx] <= val_reg;
                            neg_reg <= diff[8];
                            acc_reg <= {1'b0, pv_tab[s_idx], 16'd0};
                            j_reg <= 7'd1;
                            toff_reg <= '0;
                        end
                    end
                mccm_pkg::ST_DIV:
                    if (!div_busy)
                        step_reg <= neg_reg ? 25'(-{1'b0, div_q}) : {1'b0, div_q};
                mccm_pkg::ST_RAMP:
                    if (!ov_reg || !out_stall)
                    begin
                        if (j_reg != n_reg)
                        begin
                            ov_reg <= 1'b1;
                            acc_reg <= 25'(acc_reg + step_reg);
                            j_reg <= 7'(j_reg + 7'd1);
                            toff_reg <= 22'(toff_reg + {6'd0, spacing_reg});
                        end
                    end
                mccm_pkg::ST_OUT:
                    if (!ov_reg || !out_stall)
                        ov_reg <= 1'b1;
                mccm_pkg::ST_SCAN:
                    if (sts_reg[7:4] == mccm_pkg::CC_STATUS_HI && learn_reg)
                    begin
                        if (ch_tab[idx_reg] == sts_reg[3:0] && cc_tab[idx_reg] == d1_reg)
                        begin
                            pick_reg <= idx_reg;
                            neg_reg <= 1'b1;
                        end
                        else
                        begin
                            neg_reg <= 1'b0;
                            if (idx_reg != '0 && st_tab[idx_reg] < oldest_reg)
                            begin
                                pick_reg <= idx_reg;
                                oldest_reg <= st_tab[idx_reg];
                            end
                        end
                        idx_reg <= IW'(idx_reg + 1'b1);
                    end
                mccm_pkg::ST_LEARN_OUT:
                    if (!ov_reg || !out_stall)
                    begin
                        ov_reg <= 1'b1;
                        ch_tab[pick_reg] <= sts_reg[3:0];
                        cc_tab[pick_reg] <= d1_reg;
                        if (neg_reg)
                            st_tab[pick_reg] <= 32'(stamp_reg - 32'd1);
                        else
                        begin
                            st_tab[pick_reg] <= stamp_reg;
                            stamp_reg <= 32'(stamp_reg + 32'd1);
                        end
                    end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (!ov_reg || !out_stall)
        begin
            kind_reg <= 1'b0;
            word_reg <= '0;
            time_reg <= '0;
            ls_reg <= '0;
            lch_reg <= '0;
            lcc_reg <= '0;
            lval_reg <= '0;
            last_reg <= 1'b1;
            case (state_reg)
                mccm_pkg::ST_RAMP:
                begin
                    // integer part of the advanced accumulator
                    word_reg <= mccm_pkg::cc_word(ch_tab[s_idx], cc_tab[s_idx],
                        8'(25'(acc_reg + step_reg) >> 16));
                    time_reg <= toff_reg;
                    last_reg <= 1'b0;
                end
                mccm_pkg::ST_OUT:
                begin
                    word_reg <= mccm_pkg::cc_word(ch_tab[s_idx], cc_tab[s_idx], val_reg);
                    time_reg <= toff_reg;
                end
                mccm_pkg::ST_LEARN_OUT:
                begin
                    kind_reg <= 1'b1;
                    ls_reg <= 6'(pick_reg);
                    lch_reg <= 5'({1'b0, sts_reg[3:0]} + 5'd1);
                    lcc_reg <= d1_reg;
                    lval_reg <= d2_reg;
                end
                default: ;
            endcase
        end
    end

    assign out_valid = ov_reg;
    assign kind = kind_reg;
    assign midi_word = word_reg;
    assign time_offset = time_reg;
    assign learned_slot = ls_reg;
    assign learned_channel = lch_reg;
    assign learned_cc = lcc_reg;
    assign learned_value = lval_reg;
    assign last = last_reg;

`ifndef SYNTHESIS
    a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != mccm_pkg::ST_IDLE) |-> in_stall)
        else $error("input taken while busy");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(midi_word)))
        else $error("output changed under stall");
    a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
        (stamp_reg != $past(stamp_reg)) |-> $past(state_reg == mccm_pkg::ST_LEARN_OUT))
        else $error("stamp moved outside learn");
`endif
endmodule

FILE: tb/sv/midi_cc_mapper_with_learn_top_tb.sv
module midi_cc_mapper_with_learn_top_tb;

    localparam int NSLOT = mccm_pkg::SLOTS_DEF;

    typedef struct packed {
        logic       cmd;
        logic [5:0] slot;
        logic [7:0] channel_in;
        logic [7:0] cc_in;
        logic [7:0] value_in;
        logic [7:0] status;
        logic [7:0] data1;
        logic [7:0] data2;
    } midi_req_t;

    typedef struct packed {
        logic        kind;
        logic [23:0] midi_word;
        logic [21:0] time_offset;
        logic [5:0]  learned_slot;
        logic [4:0]  learned_channel;
        logic [7:0]  learned_cc;
        logic [7:0]  learned_value;
        logic        last;
    } midi_evt_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        cmd;
    logic [5:0]  slot;
    logic [7:0]  channel_in;
    logic [7:0]  cc_in;
    logic [7:0]  value_in;
    logic [7:0]  status;
    logic [7:0]  data1;
    logic [7:0]  data2;
    logic        out_valid;
    logic        out_stall;
    logic        kind;
    logic [23:0] midi_word;
    logic [21:0] time_offset;
    logic [5:0]  learned_slot;
    logic [4:0]  learned_channel;
    logic [7:0]  learned_cc;
    logic [7:0]  learned_value;
    logic        last;

    midi_cc_mapper_with_learn_top i_dut (.*);

    // predictor state
    logic        smooth_on;
    logic        learn_on;
    logic [6:0]  tracks;
    logic [6:0]  steps;
    logic [15:0] spacing;
    logic [3:0]  tbl_chan [NSLOT];
    logic [7:0]  tbl_cc [NSLOT];
    logic [7:0]  tbl_prev [NSLOT];
    logic [31:0] tbl_stamp [NSLOT];
    logic [31:0] stamp_now;

    midi_req_t pending_reqs[$];
    midi_evt_t expected_events[$];
    int        n_errors;
    int        n_events;
    int        n_learned;
    int        n_ramps;
    int        hold_cycles;

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic midi_evt_t word_evt(logic [3:0] ch, logic [7:0] cc, logic [7:0] v,
                                           logic [21:0] t, logic lst);
        midi_evt_t e;
        e = '0;
        e.midi_word = {v, cc, mccm_pkg::CC_STATUS_HI, ch};
        e.time_offset = t;
        e.last = lst;
        return e;
    endfunction

    task automatic predict_midi(input midi_req_t r);
        int        used;
        int        n;
        int        pick;
        int        p;
        int        stepv;
        int        acc;
        logic [31:0] oldest;
        logic [7:0]  iv;
        logic [3:0]  ch;
        bit          hit;
        midi_evt_t   e;
        used = (tracks > NSLOT) ? NSLOT : tracks;
        if (r.cmd == mccm_pkg::CMD_UPDATE) begin
            if (r.slot >= used) return;
            if (r.channel_in != mccm_pkg::NO_CHANGE) begin
                tbl_chan[r.slot] = 4'(r.channel_in - 8'd1);
                tbl_stamp[r.slot] = stamp_now;
            end
            if (r.cc_in != mccm_pkg::NO_CHANGE) begin
                tbl_cc[r.slot] = r.cc_in;
                tbl_stamp[r.slot] = stamp_now;
            end
            if (r.value_in == mccm_pkg::NO_CHANGE) return;
            tbl_stamp[r.slot] = stamp_now;
            if (!smooth_on) begin
                expected_events.push_back(word_evt(tbl_chan[r.slot], tbl_cc[r.slot],
                                                   r.value_in, '0, 1'b1));
                tbl_prev[r.slot] = r.value_in;
                return;
            end
            n = (steps < 1) ? 1 : ((steps > 64) ? 64 : steps);
            n_ramps++;
            p = tbl_prev[r.slot];
            stepv = ((int'(r.value_in) - p) * 65536) / n;
            acc = p * 65536;
            tbl_prev[r.slot] = r.value_in;
            for (int j = 0; j + 1 < n; j++) begin
                acc += stepv;
                iv = (acc < 0) ? 8'd0 : 8'(acc >>> 16);
                expected_events.push_back(word_evt(tbl_chan[r.slot], tbl_cc[r.slot], iv,
                                                   22'(j * spacing), 1'b0));
            end
            expected_events.push_back(word_evt(tbl_chan[r.slot], tbl_cc[r.slot], r.value_in,
                                               22'((n - 1) * spacing), 1'b1));
        end else begin
            if (r.status[7:4] != mccm_pkg::CC_STATUS_HI || !learn_on) return;
            ch = r.status[3:0];
            pick = 0;
            oldest = tbl_stamp[0];
            hit = 0;
            if (tbl_chan[0] == ch && tbl_cc[0] == r.data1) begin
                hit = 1;
            end else begin
                for (int i = 1; i < used; i++) begin
                    if (tbl_stamp[i] < oldest) begin
                        pick = i;
                        oldest = tbl_stamp[i];
                    end
                    if (tbl_chan[i] == ch && tbl_cc[i] == r.data1) begin
                        pick = i;
                        hit = 1;
                        break;
                    end
                end
            end
            if (hit) begin
                tbl_stamp[pick] = stamp_now - 32'd1;
            end else begin
                tbl_stamp[pick] = stamp_now;
                stamp_now = stamp_now + 32'd1;
            end
            tbl_chan[pick] = ch;
            tbl_cc[pick] = r.data1;
            e = '0;
            e.kind = 1'b1;
            e.learned_slot = 6'(pick);
            e.learned_channel = 5'(ch) + 5'd1;
            e.learned_cc = r.data1;
            e.learned_value = r.data2;
            e.last = 1'b1;
            expected_events.push_back(e);
            n_learned++;
        end
    endtask

    // note each input transfer at the edge that takes it
    bit in_taken;
    always @(posedge clk) begin
        in_taken <= rst_n && in_valid && !in_stall;
    end

    // driver: one transfer per pending item, random gap before each
    int gap_left;
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else if (!in_valid || in_taken) begin
            if (in_taken) begin
                predict_midi(pending_reqs.pop_front());
                gap_left = $urandom_range(0, 3);
            end
            if (gap_left == 0 && pending_reqs.size() > 0) begin
                in_valid <= 1'b1;
                {cmd, slot, channel_in, cc_in, value_in, status, data1, data2}
                    <= pending_reqs[0];
            end else begin
                in_valid <= 1'b0;
                if (gap_left > 0) gap_left = gap_left - 1;
            end
        end
    end

    // receiver stall, with an optional long hold-off
    int stall_left;
    always @(negedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end else if (hold_cycles > 0) begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            out_stall <= 1'b0;
            if (out_valid) stall_left <= $urandom_range(0, 3);
        end
    end

    // monitor
    always @(posedge clk) begin
        midi_evt_t got;
        midi_evt_t want;
        if (rst_n && out_valid && !out_stall) begin
            got = {kind, midi_word, time_offset, learned_slot, learned_channel, learned_cc,
                   learned_value, last};
            n_events++;
            if (expected_events.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, got);
                n_errors++;
            end else begin
                want = expected_events.pop_front();
                if (got.kind != want.kind)
                    $display("%0t: kind exp %h got %h", $realtime, want.kind, got.kind);
                if (got.midi_word != want.midi_word)
                    $display("%0t: midi_word exp %h got %h", $realtime, want.midi_word,
                             got.midi_word);
                if (got.time_offset != want.time_offset)
                    $display("%0t: time_offset exp %0d got %0d", $realtime, want.time_offset,
                             got.time_offset);
                if (got.learned_slot != want.learned_slot)
                    $display("%0t: learned_slot exp %0d got %0d", $realtime,
                             want.learned_slot, got.learned_slot);
                if (got.learned_channel != want.learned_channel)
                    $display("%0t: learned_channel exp %0d got %0d", $realtime,
                             want.learned_channel, got.learned_channel);
                if (got.learned_cc != want.learned_cc)
                    $display("%0t: learned_cc exp %h got %h", $realtime, want.learned_cc,
                             got.learned_cc);
                if (got.learned_value != want.learned_value)
                    $display("%0t: learned_value exp %h got %h", $realtime,
                             want.learned_value, got.learned_value);
                if (got.last != want.last)
                    $display("%0t: last exp %b got %b", $realtime, want.last, got.last);
                if (got != want) n_errors++;
            end
        end
    end

    task automatic set_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            mccm_pkg::REG_SMOOTH: smooth_on = val[0];
            mccm_pkg::REG_LEARN: learn_on = val[0];
            mccm_pkg::REG_TRACKS: tracks = val[6:0];
            mccm_pkg::REG_STEPS: steps = val[6:0];
            mccm_pkg::REG_SPACING: spacing = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
        while (expected_events.size() != 0) @(posedge clk);
        // ignored items may still be in flight
        repeat (NSLOT + 40) @(posedge clk);
    endtask

    function automatic midi_req_t upd(int s, int ch, int cc, int v);
        midi_req_t r;
        r = '0;
        r.cmd = mccm_pkg::CMD_UPDATE;
        r.slot = 6'(s);
        r.channel_in = 8'(ch);
        r.cc_in = 8'(cc);
        r.value_in = 8'(v);
        r.status = 8'($urandom);
        r.data1 = 8'($urandom);
        r.data2 = 8'($urandom);
        return r;
    endfunction

    function automatic midi_req_t cc_msg(int st, int d1, int d2);
        midi_req_t r;
        r = '0;
        r.cmd = mccm_pkg::CMD_MIDI;
        r.slot = 6'($urandom);
        r.channel_in = 8'($urandom);
        r.cc_in = 8'($urandom);
        r.value_in = 8'($urandom);
        r.status = 8'(st);
        r.data1 = 8'(d1);
        r.data2 = 8'(d2);
        return r;
    endfunction

    function automatic int pick_byte();
        case ($urandom_range(0, 5))
            0: return 255;
            1: return 0;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic midi_req_t random_req();
        int k;
        k = $urandom_range(0, 9);
        if (k < 5)
            return upd($urandom_range(0, 3) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 17),
                       ($urandom_range(0, 3) == 0) ? pick_byte() : $urandom_range(1, 16),
                       ($urandom_range(0, 3) == 0) ? pick_byte() : $urandom_range(0, 7),
                       pick_byte());
        else if (k < 9)
            return cc_msg({mccm_pkg::CC_STATUS_HI, 4'($urandom)},
                          $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                          : $urandom_range(0, 7), $urandom_range(0, 255));
        else
            return cc_msg($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    endfunction

    initial begin
        n_errors = 0;
        n_events = 0;
        n_learned = 0;
        n_ramps = 0;
        hold_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cfg_we = 1'b0;
        cfg_index = mccm_pkg::REG_SMOOTH;
        cfg_data = '0;
        {cmd, slot, channel_in, cc_in, value_in, status, data1, data2} = '0;
        smooth_on = 0;
        learn_on = 0;
        tracks = 7'd1;
        steps = 7'd1;
        spacing = 16'(mccm_pkg::SPACING_RESET);
        for (int i = 0; i < NSLOT; i++) begin
            tbl_chan[i] = '0;
            tbl_cc[i] = '0;
            tbl_prev[i] = '0;
            tbl_stamp[i] = '0;
        end
        stamp_now = 32'd1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, reset settings: one slot, learn off
        pending_reqs.push_back(upd(0, 1, 7, 100));
        pending_reqs.push_back(upd(0, 255, 255, 0));
        pending_reqs.push_back(upd(0, 0, 255, 127));
        pending_reqs.push_back(upd(1, 3, 3, 3));
        pending_reqs.push_back(upd(0, 16, 0, 255));
        pending_reqs.push_back(cc_msg(8'hB0, 7, 1));
        drain();

        set_reg(mccm_pkg::REG_LEARN, 16'd1);
        set_reg(mccm_pkg::REG_TRACKS, 16'd0);
        pending_reqs.push_back(cc_msg(8'hBF, 0, 9));
        pending_reqs.push_back(cc_msg(8'hBF, 0, 10));
        pending_reqs.push_back(cc_msg(8'h90, 1, 1));
        drain();

        set_reg(mccm_pkg::REG_TRACKS, 16'd64);
        set_reg(mccm_pkg::REG_SMOOTH, 16'd1);
        set_reg(mccm_pkg::REG_STEPS, 16'd64);
        set_reg(mccm_pkg::REG_SPACING, 16'hFFFF);
        pending_reqs.push_back(upd(15, 5, 74, 254));
        pending_reqs.push_back(upd(15, 255, 255, 0));
        pending_reqs.push_back(upd(16, 5, 74, 10));
        pending_reqs.push_back(cc_msg(8'hB4, 74, 50));
        pending_reqs.push_back(cc_msg(8'hB2, 20, 60));
        pending_reqs.push_back(cc_msg(8'hB2, 21, 61));
        drain();

        set_reg(mccm_pkg::REG_STEPS, 16'd0);
        set_reg(mccm_pkg::REG_SPACING, 16'd0);
        pending_reqs.push_back(upd(3, 2, 2, 200));
        pending_reqs.push_back(upd(4, 1, 1, 200));
        drain();

        // random phases over several settings
        for (int ph = 0; ph < 6; ph++) begin
            set_reg(mccm_pkg::REG_SMOOTH, 16'($urandom_range(0, 1)));
            set_reg(mccm_pkg::REG_LEARN, 16'($urandom_range(0, 4) != 0));
            set_reg(mccm_pkg::REG_TRACKS, 16'(ph == 5 ? 127 : $urandom_range(0, 20)));
            set_reg(mccm_pkg::REG_STEPS, 16'(ph == 0 ? 127 : $urandom_range(0, 9)));
            set_reg(mccm_pkg::REG_SPACING, 16'($urandom_range(0, 65535)));
            for (int k = 0; k < 72; k++) pending_reqs.push_back(random_req());
            if (ph == 2) hold_cycles = 400;
            drain();
        end

        $display("Covered %0d results, %0d learned mappings, %0d ramps.",
                 n_events, n_learned, n_ramps);
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
